[rtl/dtrp_pkg.sv]
// shared types, constants and header table for the decimal triple record parser
package dtrp_pkg;

	// fixed file header
	localparam int unsigned HEADER_LEN = 25;
	localparam logic [4:0] HEADER_END = 5'(HEADER_LEN);
	localparam logic [7:0] HDR_TEXT [32] = '{
		8'h63, 8'h72, 8'h6f, 8'h73, 8'h73, 8'h70, 8'h6f, 8'h69,
		8'h6e, 8'h74, 8'h2d, 8'h68, 8'h69, 8'h67, 8'h68, 8'h6c,
		8'h69, 8'h67, 8'h68, 8'h74, 8'h73, 8'h2d, 8'h76, 8'h31,
		8'h0a, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	// character codes
	localparam logic [7:0] CH_NEWLINE = 8'h0a;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;

	// limits
	localparam logic [24:0] BYTE_COUNT_MAX = 25'h1ff_ffff;
	localparam logic [35:0] SPINE_MAX      = 36'd65535;
	localparam logic [1:0]  LAST_FIELD     = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_MAX_WORD    = 2'd0;
	localparam logic [1:0] REG_MAX_RECORDS = 2'd1;
	localparam logic [1:0] REG_MAX_BYTES   = 2'd2;

	// reset values of the configuration registers
	localparam logic [31:0] MAX_WORD_RST    = 32'hffff_fffe;
	localparam logic [15:0] MAX_RECORDS_RST = 16'd256;
	localparam logic [23:0] MAX_BYTES_RST   = 24'd65536;

	// result queue depth
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_RECORD = 2'd0,
		KIND_OK     = 2'd1,
		KIND_FAIL   = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] spine;
		logic [31:0] start_word;
		logic [31:0] end_word;
		logic        run_last;
	} res_t;

	// push request from the parser into the result queue
	typedef struct packed {
		logic [1:0] cnt;
		res_t       first;
		res_t       second;
	} push_t;

endpackage

[rtl/dtrp_res_fifo.sv]
// small result queue: up to two pushes and one pop per cycle
module dtrp_res_fifo (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dtrp_pkg::push_t                push,
	input  logic                           pop,
	output dtrp_pkg::res_t                 head,
	output logic                           not_empty,
	output logic [dtrp_pkg::FIFO_CW-1:0]   level
);

	dtrp_pkg::res_t                 mem_q [dtrp_pkg::FIFO_DEPTH];
	logic [dtrp_pkg::FIFO_AW-1:0]   wr_ptr_q;
	logic [dtrp_pkg::FIFO_AW-1:0]   rd_ptr_q;
	logic [dtrp_pkg::FIFO_CW-1:0]   count_q;
	logic [dtrp_pkg::FIFO_AW-1:0]   wr_ptr_nx;
	logic                           do_pop;

	assign wr_ptr_nx = wr_ptr_q + dtrp_pkg::FIFO_AW'(1);
	assign do_pop    = pop && (count_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign level     = count_q;

	// entry storage
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_ptr_nx] <= push.second;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + dtrp_pkg::FIFO_AW'(push.cnt);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + dtrp_pkg::FIFO_AW'(1);
			end
			count_q <= count_q + dtrp_pkg::FIFO_CW'(push.cnt) - dtrp_pkg::FIFO_CW'(do_pop);
		end
	end

	// queue never holds more than its depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= dtrp_pkg::FIFO_CW'(dtrp_pkg::FIFO_DEPTH))
		else $error("result queue over depth");

	// a push never overruns the free space
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(count_q) + 32'(push.cnt) - 32'(do_pop)) <= dtrp_pkg::FIFO_DEPTH)
		else $error("result queue overrun");

	// pointer distance matches the fill level
	a_ptr_level: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != dtrp_pkg::FIFO_CW'(dtrp_pkg::FIFO_DEPTH)) |->
		(dtrp_pkg::FIFO_AW'(wr_ptr_q - rd_ptr_q) == dtrp_pkg::FIFO_AW'(count_q)))
		else $error("result queue pointers out of step");

endmodule

[rtl/decimal_triple_record_parser.sv]
// top level: byte stream parser for range-record text files with config registers
//
// Input channel (in_valid/in_ready) moves one item per transfer: data_byte with
// byte_valid, and end_of_data to close the file. Output channel (out_valid/out_ready)
// moves one result per transfer: a range record (kind 0) for every good line, and one
// status (kind 1 ok, kind 2 failed) after the item that carries end_of_data.
// run_last marks the last result caused by one input item.
// An accepted item lands in an input register and is parsed there once the queue has
// room; its results are registered in the result queue, and out_valid rises once they
// are stored there. The parser takes one item per cycle; the only limit is the
// four-entry result queue, which must have room for two results, so an item that yields
// a record and a status costs the output side two transfers.
// When the receiver stalls, results pile up in the queue and in_ready drops once
// fewer than two entries are free; nothing is lost. Reset (arst_n low) empties the
// queue, clears the file state and loads the register defaults. The user must write
// registers over the APB port while idle only; the block does not enforce it.
module decimal_triple_record_parser (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        end_of_data,
	// output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [15:0] spine,
	output logic [31:0] start_word,
	output logic [31:0] end_word,
	output logic        run_last,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// configuration registers
	logic [31:0] max_word_q;
	logic [15:0] max_records_q;
	logic [23:0] max_bytes_q;
	logic        cfg_wr;

	// input stage
	logic        v_s1;
	logic [7:0]  data_byte_s1;
	logic        byte_valid_s1;
	logic        end_of_data_s1;
	logic        adv_s1;
	logic        room;

	// file state
	logic [24:0] byte_count_q;
	logic [4:0]  header_pos_q;
	logic [1:0]  field_index_q;
	logic        digit_seen_q;
	logic [31:0] accumulator_q;
	logic [15:0] held_spine_q;
	logic [31:0] held_start_q;
	logic [15:0] record_count_q;
	logic        failed_q;

	// next file state
	logic [24:0] byte_count_d;
	logic [4:0]  header_pos_d;
	logic [1:0]  field_index_d;
	logic        digit_seen_d;
	logic [31:0] accumulator_d;
	logic [15:0] held_spine_d;
	logic [31:0] held_start_d;
	logic [15:0] record_count_d;
	logic        failed_d;

	// parse helpers
	logic [24:0] bc_inc;
	logic [35:0] digit_val;
	logic [35:0] digit_lim;
	logic        is_digit;
	logic        rec_fire;
	logic        file_bad;

	dtrp_pkg::push_t                 push;
	dtrp_pkg::res_t                  head;
	logic                            q_not_empty;
	logic [dtrp_pkg::FIFO_CW-1:0]    q_level;

	// apb register file
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_word_q    <= dtrp_pkg::MAX_WORD_RST;
			max_records_q <= dtrp_pkg::MAX_RECORDS_RST;
			max_bytes_q   <= dtrp_pkg::MAX_BYTES_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				dtrp_pkg::REG_MAX_WORD:    max_word_q    <= pwdata;
				dtrp_pkg::REG_MAX_RECORDS: max_records_q <= pwdata[15:0];
				dtrp_pkg::REG_MAX_BYTES:   max_bytes_q   <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			dtrp_pkg::REG_MAX_WORD:    prdata = max_word_q;
			dtrp_pkg::REG_MAX_RECORDS: prdata = {16'd0, max_records_q};
			dtrp_pkg::REG_MAX_BYTES:   prdata = {8'd0, max_bytes_q};
			default:                   prdata = 32'd0;
		endcase
	end

	// input register, advances when the queue has room for two results
	assign room     = (q_level <= dtrp_pkg::FIFO_CW'(dtrp_pkg::FIFO_DEPTH - 2));
	assign adv_s1   = v_s1 && room;
	assign in_ready = !v_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_byte_s1   <= data_byte;
			byte_valid_s1  <= byte_valid;
			end_of_data_s1 <= end_of_data;
		end
	end

	// per-byte arithmetic
	assign bc_inc    = (byte_count_q == dtrp_pkg::BYTE_COUNT_MAX) ?
		byte_count_q : byte_count_q + 25'd1;
	assign is_digit  = (data_byte_s1 >= dtrp_pkg::CH_ZERO) && (data_byte_s1 <= dtrp_pkg::CH_NINE);
	assign digit_val = ({4'd0, accumulator_q} << 3) + ({4'd0, accumulator_q} << 1)
		+ {32'd0, data_byte_s1[3:0]};
	assign digit_lim = (field_index_q == 2'd0) ? dtrp_pkg::SPINE_MAX : {4'd0, max_word_q};

	// byte step and end-of-file check
	always_comb begin
		byte_count_d   = byte_count_q;
		header_pos_d   = header_pos_q;
		field_index_d  = field_index_q;
		digit_seen_d   = digit_seen_q;
		accumulator_d  = accumulator_q;
		held_spine_d   = held_spine_q;
		held_start_d   = held_start_q;
		record_count_d = record_count_q;
		failed_d       = failed_q;
		rec_fire       = 1'b0;

		if (byte_valid_s1) begin
			byte_count_d = bc_inc;
			if (!failed_q) begin
				if (bc_inc > {1'b0, max_bytes_q}) begin
					failed_d = 1'b1;
				end else if (header_pos_q < dtrp_pkg::HEADER_END) begin
					if (data_byte_s1 != dtrp_pkg::HDR_TEXT[header_pos_q]) begin
						failed_d = 1'b1;
					end else begin
						header_pos_d = header_pos_q + 5'd1;
					end
				end else if (is_digit) begin
					if ((field_index_q > dtrp_pkg::LAST_FIELD) || (digit_val > digit_lim)) begin
						failed_d = 1'b1;
					end else begin
						accumulator_d = digit_val[31:0];
						digit_seen_d  = 1'b1;
					end
				end else if (data_byte_s1 == dtrp_pkg::CH_SPACE) begin
					if (!digit_seen_q || (field_index_q >= dtrp_pkg::LAST_FIELD)) begin
						failed_d = 1'b1;
					end else begin
						if (field_index_q == 2'd0) begin
							held_spine_d = accumulator_q[15:0];
						end else begin
							held_start_d = accumulator_q;
						end
						field_index_d = field_index_q + 2'd1;
						digit_seen_d  = 1'b0;
						accumulator_d = 32'd0;
					end
				end else if (data_byte_s1 == dtrp_pkg::CH_NEWLINE) begin
					if ((field_index_q != dtrp_pkg::LAST_FIELD) || !digit_seen_q ||
						(record_count_q >= max_records_q) || (accumulator_q < held_start_q)) begin
						failed_d = 1'b1;
					end else begin
						rec_fire       = 1'b1;
						record_count_d = record_count_q + 16'd1;
						field_index_d  = 2'd0;
						digit_seen_d   = 1'b0;
						accumulator_d  = 32'd0;
					end
				end else begin
					failed_d = 1'b1;
				end
			end
		end

		file_bad = failed_d || ((byte_count_d != 25'd0) &&
			((header_pos_d < dtrp_pkg::HEADER_END) || (field_index_d != 2'd0) || digit_seen_d));
	end

	// results pushed into the queue
	always_comb begin
		dtrp_pkg::res_t rec;
		dtrp_pkg::res_t status;

		rec.kind       = dtrp_pkg::KIND_RECORD;
		rec.spine      = held_spine_q;
		rec.start_word = held_start_q;
		rec.end_word   = accumulator_q;
		rec.run_last   = !end_of_data_s1;

		status.kind       = file_bad ? dtrp_pkg::KIND_FAIL : dtrp_pkg::KIND_OK;
		status.spine      = 16'd0;
		status.start_word = 32'd0;
		status.end_word   = 32'd0;
		status.run_last   = 1'b1;

		push.cnt    = 2'd0;
		push.first  = rec;
		push.second = status;
		if (adv_s1) begin
			if (rec_fire && end_of_data_s1) begin
				push.cnt = 2'd2;
			end else if (rec_fire) begin
				push.cnt = 2'd1;
			end else if (end_of_data_s1) begin
				push.cnt   = 2'd1;
				push.first = status;
			end
		end
	end

	// file state, cleared after the status result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= '0;
			header_pos_q   <= '0;
			field_index_q  <= '0;
			digit_seen_q   <= 1'b0;
			accumulator_q  <= '0;
			held_spine_q   <= '0;
			held_start_q   <= '0;
			record_count_q <= '0;
			failed_q       <= 1'b0;
		end else if (adv_s1) begin
			if (end_of_data_s1) begin
				byte_count_q   <= '0;
				header_pos_q   <= '0;
				field_index_q  <= '0;
				digit_seen_q   <= 1'b0;
				accumulator_q  <= '0;
				held_spine_q   <= '0;
				held_start_q   <= '0;
				record_count_q <= '0;
				failed_q       <= 1'b0;
			end else begin
				byte_count_q   <= byte_count_d;
				header_pos_q   <= header_pos_d;
				field_index_q  <= field_index_d;
				digit_seen_q   <= digit_seen_d;
				accumulator_q  <= accumulator_d;
				held_spine_q   <= held_spine_d;
				held_start_q   <= held_start_d;
				record_count_q <= record_count_d;
				failed_q       <= failed_d;
			end
		end
	end

	// result queue
	dtrp_res_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (out_ready),
		.head      (head),
		.not_empty (q_not_empty),
		.level     (q_level)
	);

	assign out_valid  = q_not_empty;
	assign kind       = head.kind;
	assign spine      = head.spine;
	assign start_word = head.start_word;
	assign end_word   = head.end_word;
	assign run_last   = head.run_last;

	// header position never runs past the header
	a_hdr_range: assert property (@(posedge clk) disable iff (!arst_n)
		header_pos_q <= dtrp_pkg::HEADER_END)
		else $error("header position past header");

	// no body field before the header is complete
	a_body_after_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		(header_pos_q < dtrp_pkg::HEADER_END) |->
		(field_index_q == 2'd0) && !digit_seen_q && (record_count_q == 16'd0))
		else $error("body state inside header");

	// with no byte counted the file state is untouched
	a_empty_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_count_q == 25'd0) |-> (header_pos_q == 5'd0) && !failed_q &&
		(record_count_q == 16'd0))
		else $error("file state moved without a byte");

	// an end item always leaves the file state cleared
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && end_of_data_s1) |=> (byte_count_q == 25'd0) && !failed_q)
		else $error("file state not cleared at end");

endmodule

[tb/tb_decimal_triple_record_parser.sv]
// testbench for the decimal triple record parser: directed files, limit settings, random traffic
module tb_decimal_triple_record_parser;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        byte_valid;
	logic        end_of_data;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  kind;
	logic [15:0] spine;
	logic [31:0] start_word;
	logic [31:0] end_word;
	logic        run_last;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// idle and stall odds, percent
	int unsigned idle_pct  = 0;
	int unsigned stall_pct = 0;
	int unsigned items_sent = 0;
	int unsigned mismatches = 0;

	// records and statuses still to come out of the block
	dtrp_pkg::res_t awaited_results [$];

	// predicted register contents
	logic [31:0] lim_word;
	logic [15:0] lim_records;
	logic [23:0] lim_bytes;

	// predicted file state
	logic [24:0] cnt_bytes;
	logic [4:0]  hdr_pos;
	logic [1:0]  field_idx;
	logic        have_digit;
	logic [31:0] acc_value;
	logic [15:0] line_spine;
	logic [31:0] line_start;
	logic [15:0] line_count;
	logic        file_bad;

	decimal_triple_record_parser DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.byte_valid (byte_valid),
		.end_of_data(end_of_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.spine      (spine),
		.start_word (start_word),
		.end_word   (end_word),
		.run_last   (run_last),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic void clear_file();
		cnt_bytes  = '0;
		hdr_pos    = '0;
		field_idx  = '0;
		have_digit = 1'b0;
		acc_value  = '0;
		line_spine = '0;
		line_start = '0;
		line_count = '0;
		file_bad   = 1'b0;
	endfunction

	// one file byte through the line grammar; returns 1 when a record completes
	function automatic bit consume_byte(input logic [7:0] b, output dtrp_pkg::res_t rec);
		logic [35:0] ceiling;
		logic [35:0] grown;
		rec = '0;
		if (cnt_bytes != dtrp_pkg::BYTE_COUNT_MAX)
			cnt_bytes = cnt_bytes + 25'd1;
		if (file_bad)
			return 1'b0;
		if (cnt_bytes > 25'(lim_bytes)) begin
			file_bad = 1'b1;
			return 1'b0;
		end
		// header bytes must match one by one
		if (hdr_pos < dtrp_pkg::HEADER_END) begin
			if (b != dtrp_pkg::HDR_TEXT[hdr_pos])
				file_bad = 1'b1;
			else
				hdr_pos = hdr_pos + 5'd1;
			return 1'b0;
		end
		// digit: multiply by ten and add, with overflow check against the field ceiling
		if (b >= dtrp_pkg::CH_ZERO && b <= dtrp_pkg::CH_NINE) begin
			ceiling = (field_idx == 2'd0) ? 36'd65535 : 36'(lim_word);
			grown = 36'(acc_value) * 36'd10 + 36'(b - dtrp_pkg::CH_ZERO);
			if (field_idx > dtrp_pkg::LAST_FIELD || grown > ceiling) begin
				file_bad = 1'b1;
				return 1'b0;
			end
			acc_value  = grown[31:0];
			have_digit = 1'b1;
			return 1'b0;
		end
		// space closes the spine or start field
		if (b == dtrp_pkg::CH_SPACE) begin
			if (!have_digit || field_idx >= dtrp_pkg::LAST_FIELD) begin
				file_bad = 1'b1;
				return 1'b0;
			end
			if (field_idx == 2'd0)
				line_spine = acc_value[15:0];
			else
				line_start = acc_value;
			field_idx  = field_idx + 2'd1;
			have_digit = 1'b0;
			acc_value  = '0;
			return 1'b0;
		end
		// newline closes the line and emits a record
		if (b == dtrp_pkg::CH_NEWLINE) begin
			if (field_idx != dtrp_pkg::LAST_FIELD || !have_digit ||
			    line_count >= lim_records || acc_value < line_start) begin
				file_bad = 1'b1;
				return 1'b0;
			end
			rec.kind       = dtrp_pkg::KIND_RECORD;
			rec.spine      = line_spine;
			rec.start_word = line_start;
			rec.end_word   = acc_value;
			rec.run_last   = 1'b1;
			line_count = line_count + 16'd1;
			field_idx  = '0;
			have_digit = 1'b0;
			acc_value  = '0;
			return 1'b1;
		end
		file_bad = 1'b1;
		return 1'b0;
	endfunction

	// expected results of one accepted item
	task automatic parse_item(input logic [7:0] b, input logic bv, input logic eod);
		dtrp_pkg::res_t rec;
		dtrp_pkg::res_t status;
		bit   got;
		logic bad;
		got = 1'b0;
		if (bv)
			got = consume_byte(b, rec);
		if (got) begin
			if (eod)
				rec.run_last = 1'b0;
			awaited_results = {awaited_results, rec};
		end
		if (eod) begin
			bad = file_bad;
			if (cnt_bytes != 0 &&
			    (hdr_pos < dtrp_pkg::HEADER_END || field_idx != 0 || have_digit))
				bad = 1'b1;
			status = '0;
			status.kind = bad ? dtrp_pkg::KIND_FAIL : dtrp_pkg::KIND_OK;
			status.run_last = 1'b1;
			awaited_results = {awaited_results, status};
			clear_file();
		end
	endtask

	function automatic logic [31:0] reg_value(input logic [1:0] idx);
		case (idx)
			dtrp_pkg::REG_MAX_WORD:    return lim_word;
			dtrp_pkg::REG_MAX_RECORDS: return 32'(lim_records);
			default:                   return 32'(lim_bytes);
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
	                                    input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// result checking and receiver stalls
	always @(posedge clk) begin
		dtrp_pkg::res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				$error("unexpected result transfer: kind %0d spine %0d", kind, spine);
				mismatches++;
			end else begin
				want = awaited_results.pop_front();
				check_field("kind", 32'(want.kind), 32'(kind));
				check_field("spine", 32'(want.spine), 32'(spine));
				check_field("start_word", want.start_word, start_word);
				check_field("end_word", want.end_word, end_word);
				check_field("run_last", 32'(want.run_last), 32'(run_last));
			end
		end
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// one input transfer, with random idle cycles ahead of it
	task automatic send_item(input logic [7:0] b, input logic bv, input logic eod);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		data_byte   <= b;
		byte_valid  <= bv;
		end_of_data <= eod;
		do @(posedge clk); while (!in_ready);
		parse_item(b, bv, eod);
		if (bv || eod)
			items_sent++;
	endtask

	// file byte, now and then preceded by an item the block ignores
	task automatic send_byte(input logic [7:0] b);
		if ($urandom_range(99) < 4)
			send_item(8'($urandom), 1'b0, 1'b0);
		send_item(b, 1'b1, 1'b0);
	endtask

	task automatic send_text(input string s);
		foreach (s[i])
			send_byte(s[i]);
	endtask

	task automatic send_header();
		for (int i = 0; i < dtrp_pkg::HEADER_LEN; i++)
			send_byte(dtrp_pkg::HDR_TEXT[i]);
	endtask

	task automatic end_file();
		send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	// let the pipeline empty out before touching registers
	task automatic wait_idle();
		int unsigned guard;
		in_valid <= 1'b0;
		guard = 0;
		while (awaited_results.size() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		if (awaited_results.size() != 0) begin
			$error("%0d expected results never arrived", awaited_results.size());
			mismatches++;
			awaited_results.delete();
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			dtrp_pkg::REG_MAX_WORD:    lim_word    = val;
			dtrp_pkg::REG_MAX_RECORDS: lim_records = val[15:0];
			default:                   lim_bytes   = val[23:0];
		endcase
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_read_check(input logic [1:0] idx);
		logic [31:0] got;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		check_field("prdata", reg_value(idx), got);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_limits(input logic [31:0] word, input logic [15:0] records,
	                          input logic [23:0] nbytes);
		wait_idle();
		apb_write(dtrp_pkg::REG_MAX_WORD, word);
		apb_write(dtrp_pkg::REG_MAX_RECORDS, 32'(records));
		apb_write(dtrp_pkg::REG_MAX_BYTES, 32'(nbytes));
		apb_read_check(dtrp_pkg::REG_MAX_WORD);
		apb_read_check(dtrp_pkg::REG_MAX_RECORDS);
		apb_read_check(dtrp_pkg::REG_MAX_BYTES);
	endtask

	// zero, the ceiling, just over it, far over it, or something inside
	function automatic longint unsigned pick_value(input longint unsigned ceiling);
		int unsigned r;
		r = $urandom_range(99);
		if (r < 10)
			return 0;
		if (r < 25)
			return ceiling;
		if (r < 30)
			return ceiling + 1 + $urandom_range(2);
		if (r < 32)
			return 64'd99999999999;
		if (r < 47)
			return $urandom_range(99) % (ceiling + 1);
		return {32'b0, $urandom} % (ceiling + 1);
	endfunction

	task automatic send_number(input longint unsigned v);
		logic [7:0]  digits [$];
		int unsigned pad;
		pad = ($urandom_range(9) == 0) ? $urandom_range(2, 1) : 0;
		do begin
			digits.push_front(8'(dtrp_pkg::CH_ZERO + v % 10));
			v = v / 10;
		end while (v != 0);
		repeat (pad) send_byte(dtrp_pkg::CH_ZERO);
		foreach (digits[i])
			send_byte(digits[i]);
	endtask

	// mostly well-formed lines, some broken ones
	task automatic send_random_line(input bit close);
		longint unsigned sp;
		longint unsigned st;
		longint unsigned en;
		int unsigned     shape;
		shape = $urandom_range(99);
		sp = pick_value(64'd65535);
		st = pick_value(64'(lim_word));
		if ($urandom_range(9) < 8 && st <= lim_word)
			en = st + ({32'b0, $urandom} % (64'(lim_word) - st + 64'd1));
		else
			en = pick_value(64'(lim_word));
		if (shape < 94) begin
			if (shape >= 88 && shape < 91)
				send_byte(dtrp_pkg::CH_SPACE);
			send_number(sp);
			if (shape >= 82 && shape < 86)
				send_byte(8'($urandom));
			send_byte(dtrp_pkg::CH_SPACE);
			if (shape >= 86 && shape < 88)
				send_byte(dtrp_pkg::CH_SPACE);
			send_number(st);
			if (shape >= 91) begin
				send_byte(dtrp_pkg::CH_SPACE);
				send_number(en);
			end else if (shape < 88) begin
				send_byte(dtrp_pkg::CH_SPACE);
				send_number(en);
			end
			if (shape >= 91 && shape < 94)
				send_byte(dtrp_pkg::CH_SPACE);
		end else begin
			repeat ($urandom_range(4)) send_byte(8'($urandom));
		end
		if (close)
			send_item(dtrp_pkg::CH_NEWLINE, 1'b1, 1'b1);
		else
			send_byte(dtrp_pkg::CH_NEWLINE);
	endtask

	task automatic send_random_file();
		int unsigned shape;
		int unsigned tail;
		int unsigned lines;
		int unsigned pos;
		shape = $urandom_range(99);
		// short header
		if (shape < 3) begin
			repeat ($urandom_range(dtrp_pkg::HEADER_LEN - 1))
				send_byte(dtrp_pkg::HDR_TEXT[0]);
			end_file();
			return;
		end
		// header, sometimes with one byte replaced
		pos = (shape < 7) ? $urandom_range(dtrp_pkg::HEADER_LEN - 1) : dtrp_pkg::HEADER_LEN;
		for (int i = 0; i < dtrp_pkg::HEADER_LEN; i++)
			send_byte((i == pos) ? 8'($urandom) : dtrp_pkg::HDR_TEXT[i]);
		lines = $urandom_range(4);
		tail = $urandom_range(99);
		for (int l = 0; l < lines; l++)
			send_random_line(l == lines - 1 && tail < 25);
		if (lines != 0 && tail < 25)
			return;
		// unterminated last line now and then
		if (tail < 33)
			send_number(pick_value(64'd65535));
		end_file();
	endtask

	task automatic test_register_access();
		apb_read_check(dtrp_pkg::REG_MAX_WORD);
		apb_read_check(dtrp_pkg::REG_MAX_RECORDS);
		apb_read_check(dtrp_pkg::REG_MAX_BYTES);
	endtask

	task automatic test_directed_format();
		// empty file, header only, extremes of the fields
		end_file();
		send_header();
		end_file();
		send_header();
		send_text("65535 0 4294967294\n0 7 7\n");
		end_file();
		// last newline and end in the same transfer
		send_header();
		send_text("1 2 3");
		send_item(dtrp_pkg::CH_NEWLINE, 1'b1, 1'b1);
		// end inside the header, wrong header byte
		for (int i = 0; i < 10; i++)
			send_byte(dtrp_pkg::HDR_TEXT[i]);
		end_file();
		send_text("x");
		end_file();
		// overflowing spine, start word above the ceiling, reversed range
		send_header();
		send_text("65536 1 2\n");
		end_file();
		send_header();
		send_text("1 4294967295 4294967295\n");
		end_file();
		send_header();
		send_text("3 9 8\n");
		end_file();
		// separators in the wrong place
		send_header();
		send_text(" 1 2 3\n");
		end_file();
		send_header();
		send_text("1  2 3\n");
		end_file();
		send_header();
		send_text("1 2 3 \n");
		end_file();
		// empty line, too few fields
		send_header();
		send_text("\n");
		end_file();
		send_header();
		send_text("1 2\n");
		end_file();
		// bad characters, record before the error stays given
		send_header();
		send_text("1 2 3\r\n");
		end_file();
		send_header();
		send_text("4 5 6\n");
		send_byte(8'hff);
		end_file();
		// unterminated line, also with a digit in the closing transfer
		send_header();
		send_text("1 2 3");
		end_file();
		send_header();
		send_text("1 2 3");
		send_item(dtrp_pkg::CH_NINE, 1'b1, 1'b1);
		// leading zeros are plain digits
		send_header();
		send_text("007 0 00\n");
		end_file();
	endtask

	task automatic test_directed_limits();
		// word ceiling of zero: a digit above it fails
		set_limits(32'd0, 16'd256, 24'd65536);
		send_header();
		send_text("0 0 0\n");
		end_file();
		send_header();
		send_text("0 0 1\n");
		end_file();
		// record count limit
		set_limits(32'hffff_fffe, 16'd0, 24'd65536);
		send_header();
		send_text("1 1 1\n");
		end_file();
		set_limits(32'hffff_fffe, 16'd1, 24'd65536);
		send_header();
		send_text("1 1 1\n2 2 2\n");
		end_file();
		// byte limit: none allowed, exactly the header, a newline over the limit
		set_limits(32'hffff_fffe, 16'd256, 24'd0);
		send_header();
		end_file();
		set_limits(32'hffff_fffe, 16'd256, 24'(dtrp_pkg::HEADER_LEN));
		send_header();
		end_file();
		send_header();
		send_text("1");
		end_file();
		set_limits(32'hffff_fffe, 16'd256, 24'(dtrp_pkg::HEADER_LEN + 5));
		send_header();
		send_text("1 2 3\n");
		end_file();
		set_limits(32'hffff_fffe, 16'hffff, 24'hff_ffff);
	endtask

	// one limit setting per phase of idle and stall odds
	task automatic test_random_traffic();
		int unsigned first;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					idle_pct = 0;  stall_pct = 0;
					set_limits(32'hffff_fffe, 16'hffff, 24'hff_ffff);
				end
				1: begin
					idle_pct = 67; stall_pct = 0;
					set_limits(32'd0, 16'd0, 24'd0);
				end
				2: begin
					idle_pct = 0;  stall_pct = 67;
					set_limits($urandom_range(5000), 16'($urandom_range(4, 1)),
					           24'($urandom_range(160, 40)));
				end
				default: begin
					idle_pct = 22; stall_pct = 22;
					set_limits($urandom_range(32'hffff_fffe, 0),
					           16'($urandom_range(65535)),
					           24'($urandom_range(24'hff_ffff, dtrp_pkg::HEADER_LEN)));
				end
			endcase
			first = items_sent;
			while (items_sent - first < 50)
				send_random_file();
		end
	endtask

	// test sequence
	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		data_byte   = '0;
		byte_valid  = 1'b0;
		end_of_data = 1'b0;
		out_ready   = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		lim_word    = dtrp_pkg::MAX_WORD_RST;
		lim_records = dtrp_pkg::MAX_RECORDS_RST;
		lim_bytes   = dtrp_pkg::MAX_BYTES_RST;
		clear_file();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_register_access();
		test_directed_format();
		test_directed_limits();
		test_random_traffic();
		wait_idle();
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
